### hw/rtl/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared types and constants for the bounded card list engine: sizes,
// command codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package bcle_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IN_IDX_W = 6;
   localparam int SUIT_W   = 2;
   localparam int VALUE_W  = 4;
   localparam int CARD_W   = SUIT_W + VALUE_W;
   localparam int CMD_W    = 3;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 3'd0,
      CMD_PUSH    = 3'd1,
      CMD_POP     = 3'd2,
      CMD_SWAP    = 3'd3,
      CMD_GET     = 3'd4,
      CMD_DEL_AT  = 3'd5,
      CMD_DEL_VAL = 3'd6
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CAPTURE,
      ST_SWAP_RB,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_PUSH,
      OP_POP,
      OP_GET,
      OP_REJECT,
      OP_CAPTURE,
      OP_SWAP_RA,
      OP_SWAP_RB,
      OP_SWAP_WA,
      OP_SWAP_WB,
      OP_SCAN_INIT,
      OP_SCAN_STEP,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             empty;
      logic             ia_bad;
      logic             swap_bad;
      logic             scan_done;
      logic             rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/bcle_dp.sv
// ----------------------------------------------------------------------------
// bcle_dp
// Datapath: entry store, count, request fields, compaction pointers and the
// response register. Acts on one operation code from the controller a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcle_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bcle_pkg::dp_cmd_type             dp_cmd,
   output bcle_pkg::dp_status_type               dp_status,
   input  wire logic [bcle_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [bcle_pkg::IN_IDX_W-1:0]    req_index_a,
   input  wire logic [bcle_pkg::IN_IDX_W-1:0]    req_index_b,
   input  wire logic [bcle_pkg::SUIT_W-1:0]      req_card_suit,
   input  wire logic [bcle_pkg::VALUE_W-1:0]     req_card_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bcle_pkg::SUIT_W-1:0]           rsp_out_suit,
   output logic [bcle_pkg::VALUE_W-1:0]          rsp_out_value,
   output logic [bcle_pkg::CNT_W-1:0]            rsp_entry_count,
   output logic                                  rsp_status
);

   // entry store, single write port and one registered read port
   logic [bcle_pkg::CARD_W-1:0] mem [bcle_pkg::CAPACITY];
   logic                        mem_we;
   logic [bcle_pkg::IDX_W-1:0]  mem_waddr;
   logic [bcle_pkg::IDX_W-1:0]  mem_raddr;
   logic [bcle_pkg::CARD_W-1:0] mem_wdata;
   logic [bcle_pkg::CARD_W-1:0] rdata_ff;

   logic [bcle_pkg::CMD_W-1:0]    cmd_ff,   cmd_in;
   logic [bcle_pkg::IN_IDX_W-1:0] ia_ff,    ia_in;
   logic [bcle_pkg::IN_IDX_W-1:0] ib_ff,    ib_in;
   logic [bcle_pkg::CARD_W-1:0]   card_ff,  card_in;
   logic [bcle_pkg::CARD_W-1:0]   got_ff,   got_in;
   logic [bcle_pkg::CARD_W-1:0]   tmp_ff,   tmp_in;
   logic                          stat_ff,  stat_in;
   logic [bcle_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [bcle_pkg::CNT_W-1:0]    rptr_ff,  rptr_in;
   logic [bcle_pkg::CNT_W-1:0]    wptr_ff,  wptr_in;
   logic                          pend_ff,  pend_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bcle_pkg::CARD_W-1:0]   rsp_card_ff,  rsp_card_in;
   logic [bcle_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                          rsp_stat_ff,  rsp_stat_in;

   logic [bcle_pkg::CNT_W-1:0]    ia_cnt;
   logic [bcle_pkg::CNT_W-1:0]    ib_cnt;
   logic [bcle_pkg::CNT_W-1:0]    count_dec;
   logic                          rd_more;
   logic                          keep;

   assign ia_cnt    = bcle_pkg::CNT_W'(ia_ff);
   assign ib_cnt    = bcle_pkg::CNT_W'(ib_ff);
   assign count_dec = count_ff - bcle_pkg::CNT_W'(1);
   assign rd_more   = (rptr_ff < count_ff);
   // delete_at keeps every entry it walks; delete_value drops matches
   assign keep      = (cmd_ff == bcle_pkg::CMD_DEL_AT) || (rdata_ff != card_ff);

   always_comb begin
      dp_status.cmd       = cmd_ff;
      dp_status.full      = (count_ff >= bcle_pkg::CAP_COUNT);
      dp_status.empty     = (count_ff == '0);
      dp_status.ia_bad    = (ia_cnt >= count_ff);
      dp_status.swap_bad  = (ia_cnt >= count_ff) || (ib_cnt >= count_ff);
      dp_status.scan_done = !rd_more && !pend_ff;
      dp_status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      card_in      = card_ff;
      got_in       = got_ff;
      tmp_in       = tmp_ff;
      stat_in      = stat_ff;
      count_in     = count_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      pend_in      = pend_ff;
      rsp_card_in  = rsp_card_ff;
      rsp_count_in = rsp_count_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = ia_ff[bcle_pkg::IDX_W-1:0];
      mem_wdata    = rdata_ff;
      mem_raddr    = ia_ff[bcle_pkg::IDX_W-1:0];

      case (dp_cmd.op)
         bcle_pkg::OP_ACCEPT: begin
            cmd_in  = req_cmd;
            ia_in   = req_index_a;
            ib_in   = req_index_b;
            card_in = {req_card_suit, req_card_value};
            got_in  = '0;
            stat_in = 1'b0;
         end
         bcle_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         bcle_pkg::OP_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[bcle_pkg::IDX_W-1:0];
            mem_wdata = card_ff;
            count_in  = count_ff + bcle_pkg::CNT_W'(1);
         end
         bcle_pkg::OP_POP: begin
            mem_raddr = count_dec[bcle_pkg::IDX_W-1:0];
            count_in  = count_dec;
         end
         bcle_pkg::OP_GET,
         bcle_pkg::OP_SWAP_RA: begin
            mem_raddr = ia_ff[bcle_pkg::IDX_W-1:0];
         end
         bcle_pkg::OP_REJECT: begin
            stat_in = 1'b1;
         end
         bcle_pkg::OP_CAPTURE: begin
            got_in = rdata_ff;
         end
         bcle_pkg::OP_SWAP_RB: begin
            mem_raddr = ib_ff[bcle_pkg::IDX_W-1:0];
            tmp_in    = rdata_ff;
         end
         bcle_pkg::OP_SWAP_WA: begin
            mem_we    = 1'b1;
            mem_waddr = ia_ff[bcle_pkg::IDX_W-1:0];
            mem_wdata = rdata_ff;
         end
         bcle_pkg::OP_SWAP_WB: begin
            mem_we    = 1'b1;
            mem_waddr = ib_ff[bcle_pkg::IDX_W-1:0];
            mem_wdata = tmp_ff;
         end
         bcle_pkg::OP_SCAN_INIT: begin
            pend_in = 1'b0;
            if (cmd_ff == bcle_pkg::CMD_DEL_AT) begin
               rptr_in = ia_cnt + bcle_pkg::CNT_W'(1);
               wptr_in = ia_cnt;
            end else begin
               rptr_in = '0;
               wptr_in = '0;
            end
         end
         bcle_pkg::OP_SCAN_STEP: begin
            // read ahead at rptr, write back last cycle's entry at wptr
            mem_raddr = rptr_ff[bcle_pkg::IDX_W-1:0];
            mem_waddr = wptr_ff[bcle_pkg::IDX_W-1:0];
            mem_wdata = rdata_ff;
            if (pend_ff && keep) begin
               mem_we  = 1'b1;
               wptr_in = wptr_ff + bcle_pkg::CNT_W'(1);
            end
            pend_in = rd_more;
            if (rd_more) begin
               rptr_in = rptr_ff + bcle_pkg::CNT_W'(1);
            end
            if (!rd_more && !pend_ff) begin
               count_in = wptr_ff;
            end
         end
         bcle_pkg::OP_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_card_in  = got_ff;
            rsp_count_in = count_ff;
            rsp_stat_in  = stat_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      card_ff      <= card_in;
      got_ff       <= got_in;
      tmp_ff       <= tmp_in;
      stat_ff      <= stat_in;
      rptr_ff      <= rptr_in;
      wptr_ff      <= wptr_in;
      rsp_card_ff  <= rsp_card_in;
      rsp_count_ff <= rsp_count_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_suit    = rsp_card_ff[bcle_pkg::VALUE_W +: bcle_pkg::SUIT_W];
   assign rsp_out_value   = rsp_card_ff[bcle_pkg::VALUE_W-1:0];
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_stat_ff;

endmodule

`default_nettype wire

### hw/rtl/bcle_ctrl.sv
// ----------------------------------------------------------------------------
// bcle_ctrl
// Controller: sequences each request through the datapath, at most one
// datapath operation per cycle, and holds off new requests while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module bcle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire bcle_pkg::dp_status_type dp_status,
   output bcle_pkg::dp_cmd_type         dp_cmd
);

   bcle_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      dp_cmd.op   = bcle_pkg::OP_NONE;
      req_stall   = (state_ff != bcle_pkg::ST_IDLE);

      case (state_ff)
         bcle_pkg::ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = bcle_pkg::OP_ACCEPT;
               state_in  = bcle_pkg::ST_DISPATCH;
            end
         end
         bcle_pkg::ST_DISPATCH: begin
            state_in = bcle_pkg::ST_DONE;
            case (dp_status.cmd)
               bcle_pkg::CMD_CLEAR: begin
                  dp_cmd.op = bcle_pkg::OP_CLEAR;
               end
               bcle_pkg::CMD_PUSH: begin
                  dp_cmd.op = dp_status.full ? bcle_pkg::OP_REJECT : bcle_pkg::OP_PUSH;
               end
               bcle_pkg::CMD_POP: begin
                  if (dp_status.empty) begin
                     dp_cmd.op = bcle_pkg::OP_REJECT;
                  end else begin
                     dp_cmd.op = bcle_pkg::OP_POP;
                     state_in  = bcle_pkg::ST_CAPTURE;
                  end
               end
               bcle_pkg::CMD_GET: begin
                  if (dp_status.ia_bad) begin
                     dp_cmd.op = bcle_pkg::OP_REJECT;
                  end else begin
                     dp_cmd.op = bcle_pkg::OP_GET;
                     state_in  = bcle_pkg::ST_CAPTURE;
                  end
               end
               bcle_pkg::CMD_SWAP: begin
                  if (dp_status.swap_bad) begin
                     dp_cmd.op = bcle_pkg::OP_REJECT;
                  end else begin
                     dp_cmd.op = bcle_pkg::OP_SWAP_RA;
                     state_in  = bcle_pkg::ST_SWAP_RB;
                  end
               end
               bcle_pkg::CMD_DEL_AT: begin
                  if (dp_status.ia_bad) begin
                     dp_cmd.op = bcle_pkg::OP_REJECT;
                  end else begin
                     dp_cmd.op = bcle_pkg::OP_SCAN_INIT;
                     state_in  = bcle_pkg::ST_SCAN;
                  end
               end
               bcle_pkg::CMD_DEL_VAL: begin
                  dp_cmd.op = bcle_pkg::OP_SCAN_INIT;
                  state_in  = bcle_pkg::ST_SCAN;
               end
               default: begin
                  dp_cmd.op = bcle_pkg::OP_REJECT;
               end
            endcase
         end
         bcle_pkg::ST_CAPTURE: begin
            dp_cmd.op = bcle_pkg::OP_CAPTURE;
            state_in  = bcle_pkg::ST_DONE;
         end
         bcle_pkg::ST_SWAP_RB: begin
            dp_cmd.op = bcle_pkg::OP_SWAP_RB;
            state_in  = bcle_pkg::ST_SWAP_WA;
         end
         bcle_pkg::ST_SWAP_WA: begin
            dp_cmd.op = bcle_pkg::OP_SWAP_WA;
            state_in  = bcle_pkg::ST_SWAP_WB;
         end
         bcle_pkg::ST_SWAP_WB: begin
            dp_cmd.op = bcle_pkg::OP_SWAP_WB;
            state_in  = bcle_pkg::ST_DONE;
         end
         bcle_pkg::ST_SCAN: begin
            dp_cmd.op = bcle_pkg::OP_SCAN_STEP;
            if (dp_status.scan_done) begin
               state_in = bcle_pkg::ST_DONE;
            end
         end
         bcle_pkg::ST_DONE: begin
            if (dp_status.rsp_free) begin
               dp_cmd.op = bcle_pkg::OP_RESPOND;
               state_in  = bcle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/bounded_card_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_card_list_engine
// Ordered list of up to CAPACITY cards with clear, push, pop, swap, get,
// delete-at and delete-value. One response per request.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req_    | in        | req_valid/req_stall  | cmd, index_a, index_b, card
//   rsp_    | out       | rsp_valid/rsp_stall  | out_suit, out_value, count, status
//
// Ordering: one request at a time. An accepted request is dispatched; clear,
//   push and rejected requests then respond, pop and get capture the read
//   entry first, swap reads a and b and then writes a and b, and the deletes
//   step through the N entries walked (count minus index_a minus one for
//   delete_at, count for delete_value). The single read port of the entry
//   store sets the delete time: one entry read and at most one written per cycle.
// Reset: synchronous, active high; empties the list. Store contents are not
//   cleared; only entries below the count are ever used.
// Stalls: the response sits in an output register, so a new request is taken
//   while it waits; that request only blocks on completion if rsp_stall holds.
//
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_card_list_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [bcle_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [bcle_pkg::IN_IDX_W-1:0] req_index_a,
   input  wire logic [bcle_pkg::IN_IDX_W-1:0] req_index_b,
   input  wire logic [bcle_pkg::SUIT_W-1:0]   req_card_suit,
   input  wire logic [bcle_pkg::VALUE_W-1:0]  req_card_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bcle_pkg::SUIT_W-1:0]        rsp_out_suit,
   output logic [bcle_pkg::VALUE_W-1:0]       rsp_out_value,
   output logic [bcle_pkg::CNT_W-1:0]         rsp_entry_count,
   output logic                               rsp_status
);

   // controller -> datapath operation, datapath -> controller flags
   bcle_pkg::dp_cmd_type    dp_cmd;
   bcle_pkg::dp_status_type dp_status;

   bcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // request fields are latched by the datapath on the accept operation
   bcle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .req_cmd         (req_cmd),
      .req_index_a     (req_index_a),
      .req_index_b     (req_index_b),
      .req_card_suit   (req_card_suit),
      .req_card_value  (req_card_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_suit    (rsp_out_suit),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

### hw/rtl/bcle_checker.sv
// ----------------------------------------------------------------------------
// bcle_checker
// Port-level checks for the card list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcle_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [bcle_pkg::SUIT_W-1:0]   rsp_out_suit,
   input wire logic [bcle_pkg::VALUE_W-1:0]  rsp_out_value,
   input wire logic [bcle_pkg::CNT_W-1:0]    rsp_entry_count,
   input wire logic                          rsp_status
);

   // a held response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a held response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_suit) && $stable(rsp_out_value)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // engine works on one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // count never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= bcle_pkg::CAP_COUNT)
      else $error("entry count above capacity");

   // rejected requests return a zero card
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_out_suit == '0 && rsp_out_value == '0)
      else $error("rejected request returned a card");

endmodule

bind bounded_card_list_engine bcle_checker u_bcle_checker (.*);

`default_nettype wire
